// ----- hw/rtl/xcrc_pkg.sv -----
`timescale 1ns / 1ps

package xcrc_pkg;

    localparam int PAYLOAD_BYTES = 128;
    localparam int ADDR_W        = $clog2(PAYLOAD_BYTES);
    localparam int FILL_W        = $clog2(PAYLOAD_BYTES + 1);
    localparam int IDX_W         = $clog2(PAYLOAD_BYTES + 5);

    // Frame layout: SOH, block, complement, payload, CRC high, CRC low.
    localparam logic [IDX_W-1:0] IDX_SOH     = IDX_W'(0);
    localparam logic [IDX_W-1:0] IDX_BLOCK   = IDX_W'(1);
    localparam logic [IDX_W-1:0] IDX_COMPL   = IDX_W'(2);
    localparam logic [IDX_W-1:0] IDX_PAYLOAD = IDX_W'(3);
    localparam logic [IDX_W-1:0] IDX_CRC_HI  = IDX_W'(PAYLOAD_BYTES + 3);
    localparam logic [IDX_W-1:0] IDX_CRC_LO  = IDX_W'(PAYLOAD_BYTES + 4);

    localparam logic [7:0]  BYTE_SOH  = 8'h01;
    localparam logic [7:0]  BYTE_EOT  = 8'h04;
    localparam logic [7:0]  BYTE_ACK  = 8'h06;
    localparam logic [7:0]  BYTE_NAK  = 8'h15;
    localparam logic [7:0]  BYTE_SYNC = 8'h43;
    localparam logic [15:0] CRC_POLY  = 16'h1021;

    typedef enum logic [1:0] {
        ACT_DATA = 2'd0,
        ACT_RX   = 2'd1,
        ACT_SLOT = 2'd2,
        ACT_EOF  = 2'd3
    } act_t;

    typedef enum logic [2:0] {
        PH_COLLECT  = 3'd0,
        PH_SEND     = 3'd1,
        PH_WAIT     = 3'd2,
        PH_EOT_WAIT = 3'd3,
        PH_DONE     = 3'd4
    } phase_t;

    typedef enum logic [3:0] {
        EV_NONE       = 4'd0,
        EV_STORED     = 4'd1,
        EV_REFUSED    = 4'd2,
        EV_SYNC       = 4'd3,
        EV_ACKED      = 4'd4,
        EV_NACKED     = 4'd5,
        EV_UNEXPECTED = 4'd6,
        EV_EOT_ACKED  = 4'd7,
        EV_EOT_NACKED = 4'd8
    } event_t;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] value;
    } item_t;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        event_t     event_res;
        logic [7:0] block_number;
        logic [7:0] retry_count;
        logic       done_res;
    } result_t;

    // One CRC-16/XMODEM update over a whole byte, MSB first.
    function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] data);
        logic [15:0] c;
        c = crc ^ {data, 8'h00};
        for (int b = 0; b < 8; b++) begin
            if (c[15])
            begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ----- hw/rtl/xcrc_if.sv -----
`timescale 1ns / 1ps

interface xcrc_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [7:0] value;

    modport source (output valid, output action, output value, input ready);
    modport sink   (input valid, input action, input value, output ready);
endinterface

interface xcrc_rsp_if;
    logic       valid;
    logic       ready;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic [3:0] event_res;
    logic [7:0] block_number;
    logic [7:0] retry_count;
    logic       done_res;

    modport source (output valid, output tx_valid, output tx_byte, output event_res,
                    output block_number, output retry_count, output done_res,
                    input ready);
    modport sink   (input valid, input tx_valid, input tx_byte, input event_res,
                    input block_number, input retry_count, input done_res,
                    output ready);
endinterface

// ----- hw/rtl/xmodem_crc_sender.sv -----
`timescale 1ns / 1ps

// Each item is held in the input register, and its result is then loaded into the result
// register; without back-pressure one item and one result a cycle.
// The frame index steps by one per frame byte and the CRC by one eight-bit step per payload
// byte; the packet store is read at the next frame index, so its read data is ready for that byte.
// Reset (rst_n, asynchronous, active low) returns to collecting, block number one, no
// retries, not synchronised; the packet store keeps its contents and needs no clearing.
module xmodem_crc_sender (
    input logic       clk,
    input logic       rst_n,
    xcrc_cmd_if.sink  cmd,
    xcrc_rsp_if.source rsp
);

    logic              in_valid_reg, in_valid_next;
    xcrc_pkg::item_t   in_item_reg, in_item_next;
    logic              out_valid_reg, out_valid_next;
    xcrc_pkg::result_t out_res_reg, out_res_next;
    logic              room;
    logic              fire;
    xcrc_pkg::result_t res;

    assign room      = !out_valid_reg || rsp.ready;
    assign fire      = in_valid_reg && room;
    assign cmd.ready = !in_valid_reg || fire;

    xcrc_engine u_engine (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .item  (in_item_reg),
        .res   (res)
    );

    always_comb
    begin
        in_valid_next  = in_valid_reg;
        in_item_next   = in_item_reg;
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        if (cmd.valid && cmd.ready)
        begin
            in_valid_next = 1'b1;
            in_item_next  = '{action: cmd.action, value: cmd.value};
        end
        else if (fire)
        begin
            in_valid_next = 1'b0;
        end
        if (fire)
        begin
            out_valid_next = 1'b1;
            out_res_next   = res;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_item_reg <= in_item_next;
        out_res_reg <= out_res_next;
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.tx_valid     = out_res_reg.tx_valid;
    assign rsp.tx_byte      = out_res_reg.tx_byte;
    assign rsp.event_res    = out_res_reg.event_res;
    assign rsp.block_number = out_res_reg.block_number;
    assign rsp.retry_count  = out_res_reg.retry_count;
    assign rsp.done_res     = out_res_reg.done_res;

    // A transmitted byte only ever comes from a free transmit slot, which raises no event.
    assert property (@(posedge clk) disable iff (!rst_n)
        fire && res.tx_valid |-> res.event_res == xcrc_pkg::EV_NONE)
        else $error("transmitted byte carries an event");

    // A held item is not lost while the result register is blocked.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !room |=> in_valid_reg && $stable(in_item_reg))
        else $error("held item changed while stalled");

    // Once the transfer is finished it stays finished.
    assert property (@(posedge clk) disable iff (!rst_n)
        fire && res.done_res |=> !fire || res.done_res)
        else $error("done status dropped");

    // A result taken with nothing new behind it leaves the output empty.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && rsp.ready && !fire |=> !out_valid_reg)
        else $error("result repeated");

endmodule

// ----- hw/rtl/xcrc_ram.sv -----
`timescale 1ns / 1ps

module xcrc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/xcrc_engine.sv -----
`timescale 1ns / 1ps

module xcrc_engine (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             fire,
    input  xcrc_pkg::item_t  item,
    output xcrc_pkg::result_t res
);

    xcrc_pkg::phase_t                   phase_reg, phase_next;
    logic [xcrc_pkg::FILL_W-1:0]        fill_reg, fill_next;
    logic [xcrc_pkg::IDX_W-1:0]         index_reg, index_next;
    logic [15:0]                        crc_reg, crc_next;
    logic [7:0]                         block_reg, block_next;
    logic [7:0]                         retries_reg, retries_next;
    logic                               synced_reg, synced_next;
    logic                               ended_reg, ended_next;

    logic                               sending;
    logic [xcrc_pkg::IDX_W-1:0]         frame_idx;
    logic [15:0]                        frame_crc;
    logic [xcrc_pkg::IDX_W-1:0]         pay_k;
    logic [7:0]                         pay_byte;
    logic                               tx_valid;
    logic [7:0]                         tx_byte;
    xcrc_pkg::event_t                   ev;
    logic                               wr_en;
    logic [7:0]                         rd_data;
    logic [xcrc_pkg::ADDR_W-1:0]        rd_addr;

    // The read address follows the next frame index, so the registered read
    // data is ready when that payload byte is due.
    assign rd_addr = xcrc_pkg::ADDR_W'(index_next - xcrc_pkg::IDX_PAYLOAD);

    xcrc_ram #(
        .WIDTH (8),
        .DEPTH (xcrc_pkg::PAYLOAD_BYTES)
    ) u_store (
        .clk   (clk),
        .we    (wr_en),
        .waddr (fill_reg[xcrc_pkg::ADDR_W-1:0]),
        .wdata (item.value),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    assign pay_k    = frame_idx - xcrc_pkg::IDX_PAYLOAD;
    assign pay_byte = (pay_k < xcrc_pkg::IDX_W'(fill_reg)) ? rd_data : 8'h00;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= xcrc_pkg::PH_COLLECT;
            fill_reg    <= '0;
            index_reg   <= '0;
            crc_reg     <= '0;
            block_reg   <= 8'd1;
            retries_reg <= '0;
            synced_reg  <= 1'b0;
            ended_reg   <= 1'b0;
        end
        else
        begin
            phase_reg   <= phase_next;
            fill_reg    <= fill_next;
            index_reg   <= index_next;
            crc_reg     <= crc_next;
            block_reg   <= block_next;
            retries_reg <= retries_next;
            synced_reg  <= synced_next;
            ended_reg   <= ended_next;
        end
    end

    always_comb
    begin
        phase_next   = phase_reg;
        fill_next    = fill_reg;
        index_next   = index_reg;
        crc_next     = crc_reg;
        block_next   = block_reg;
        retries_next = retries_reg;
        synced_next  = synced_reg;
        ended_next   = ended_reg;
        tx_valid     = 1'b0;
        tx_byte      = 8'h00;
        ev           = xcrc_pkg::EV_NONE;
        wr_en        = 1'b0;
        sending      = 1'b0;
        frame_idx    = index_reg;
        frame_crc    = crc_reg;

        if (fire)
        begin
            unique case (xcrc_pkg::act_t'(item.action))
                xcrc_pkg::ACT_DATA:
                begin
                    if (phase_reg == xcrc_pkg::PH_COLLECT && !ended_reg
                        && fill_reg < xcrc_pkg::FILL_W'(xcrc_pkg::PAYLOAD_BYTES))
                    begin
                        wr_en     = 1'b1;
                        fill_next = fill_reg + 1'b1;
                        ev        = xcrc_pkg::EV_STORED;
                    end
                    else
                    begin
                        ev = xcrc_pkg::EV_REFUSED;
                    end
                end
                xcrc_pkg::ACT_RX:
                begin
                    priority if (phase_reg == xcrc_pkg::PH_COLLECT
                                 && item.value == xcrc_pkg::BYTE_SYNC)
                    begin
                        synced_next = 1'b1;
                        ev          = xcrc_pkg::EV_SYNC;
                    end
                    else if (phase_reg == xcrc_pkg::PH_WAIT
                             && item.value == xcrc_pkg::BYTE_ACK)
                    begin
                        block_next   = block_reg + 8'd1;
                        retries_next = '0;
                        fill_next    = '0;
                        phase_next   = xcrc_pkg::PH_COLLECT;
                        ev           = xcrc_pkg::EV_ACKED;
                    end
                    else if (phase_reg == xcrc_pkg::PH_WAIT
                             && item.value == xcrc_pkg::BYTE_NAK)
                    begin
                        phase_next = xcrc_pkg::PH_SEND;
                        index_next = '0;
                        crc_next   = '0;
                        ev         = xcrc_pkg::EV_NACKED;
                    end
                    else if (phase_reg == xcrc_pkg::PH_EOT_WAIT
                             && item.value == xcrc_pkg::BYTE_ACK)
                    begin
                        phase_next = xcrc_pkg::PH_DONE;
                        ev         = xcrc_pkg::EV_EOT_ACKED;
                    end
                    else if (phase_reg == xcrc_pkg::PH_EOT_WAIT
                             && item.value == xcrc_pkg::BYTE_NAK)
                    begin
                        phase_next = xcrc_pkg::PH_DONE;
                        ev         = xcrc_pkg::EV_EOT_NACKED;
                    end
                    else
                    begin
                        ev = xcrc_pkg::EV_UNEXPECTED;
                    end
                end
                xcrc_pkg::ACT_SLOT:
                begin
                    if (phase_reg == xcrc_pkg::PH_COLLECT && synced_reg)
                    begin
                        if (fill_reg >= xcrc_pkg::FILL_W'(xcrc_pkg::PAYLOAD_BYTES)
                            || (ended_reg && fill_reg != '0))
                        begin
                            sending   = 1'b1;
                            frame_idx = '0;
                            frame_crc = '0;
                        end
                        else if (ended_reg)
                        begin
                            phase_next = xcrc_pkg::PH_EOT_WAIT;
                            tx_valid   = 1'b1;
                            tx_byte    = xcrc_pkg::BYTE_EOT;
                        end
                    end
                    else if (phase_reg == xcrc_pkg::PH_SEND)
                    begin
                        sending = 1'b1;
                    end

                    if (sending)
                    begin
                        tx_valid   = 1'b1;
                        phase_next = xcrc_pkg::PH_SEND;
                        crc_next   = frame_crc;
                        priority if (frame_idx == xcrc_pkg::IDX_SOH)
                        begin
                            tx_byte = xcrc_pkg::BYTE_SOH;
                            if (retries_reg != 8'hFF)
                            begin
                                retries_next = retries_reg + 8'd1;
                            end
                        end
                        else if (frame_idx == xcrc_pkg::IDX_BLOCK)
                        begin
                            tx_byte = block_reg;
                        end
                        else if (frame_idx == xcrc_pkg::IDX_COMPL)
                        begin
                            tx_byte = ~block_reg;
                        end
                        else if (frame_idx < xcrc_pkg::IDX_CRC_HI)
                        begin
                            tx_byte  = pay_byte;
                            crc_next = xcrc_pkg::crc_step(frame_crc, pay_byte);
                        end
                        else if (frame_idx == xcrc_pkg::IDX_CRC_HI)
                        begin
                            tx_byte = frame_crc[15:8];
                        end
                        else
                        begin
                            tx_byte = frame_crc[7:0];
                        end

                        if (frame_idx >= xcrc_pkg::IDX_CRC_LO)
                        begin
                            phase_next = xcrc_pkg::PH_WAIT;
                            index_next = '0;
                        end
                        else
                        begin
                            index_next = frame_idx + 1'b1;
                        end
                    end
                end
                xcrc_pkg::ACT_EOF:
                begin
                    ended_next = 1'b1;
                end
                default:
                begin
                    ev = xcrc_pkg::EV_NONE;
                end
            endcase
        end
    end

    assign res.tx_valid     = tx_valid;
    assign res.tx_byte      = tx_byte;
    assign res.event_res    = ev;
    assign res.block_number = block_next;
    assign res.retry_count  = retries_next;
    assign res.done_res     = (phase_next == xcrc_pkg::PH_DONE);

endmodule
